FILE: src/sort_and_find_duplicate_core_defines.svh
// Assertion macros for the checker of the sort core.
`ifndef SORT_AND_FIND_DUPLICATE_CORE_DEFINES_SVH
`define SORT_AND_FIND_DUPLICATE_CORE_DEFINES_SVH

// Same-cycle implication, muted while reset is asserted.
`define SFD_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("sort core check failed");

// Next-cycle implication, muted while reset is asserted.
`define SFD_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("sort core check failed");

`endif

FILE: src/sfd_pkg.sv
// Shared types and constants of the sort and duplicate-find core.
package sfd_pkg;

    localparam int KEY_W           = 16;
    localparam int ALLOW_W         = 4;
    localparam int CFG_W           = 4;
    localparam int POS_W           = 3;
    localparam int MAX_ENTRIES_DEF = 8;
    localparam logic [CFG_W-1:0] PROBE_COUNT_RST = CFG_W'(8);

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [ALLOW_W-1:0] allow;
    } entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS_READ,
        ST_INS_CMP,
        ST_SCAN_READ,
        ST_SCAN_CHECK,
        ST_EMIT_READ,
        ST_EMIT_LOAD
    } state_t;

endpackage

FILE: src/sfd_entry_ram.sv
// Entry store: one write port, one read port with registered read data.
module sfd_entry_ram #(
    parameter int DEPTH = sfd_pkg::MAX_ENTRIES_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic            aclk,
    input  logic            wr_en,
    input  logic [AW-1:0]   wr_addr,
    input  sfd_pkg::entry_t wr_data,
    input  logic            rd_en,
    input  logic [AW-1:0]   rd_addr,
    output sfd_pkg::entry_t rd_data
);

    sfd_pkg::entry_t mem [DEPTH];
    sfd_pkg::entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: src/sort_and_find_duplicate_core.sv
// Each load inserts its word, moving larger stored words up one slot at a time. The word
// that completes a set of n adds a scan of the n stored words, then the sorted results
// leave one word at a time, set by the single RAM port and held while m_ready is low.
// No new word is taken until the last result of a set is loaded for output.
// Reset clears the sequencer, load count, output valid and sets probe_count to 8;
// the entry store is not cleared (slots are always written before they are read).
module sort_and_find_duplicate_core #(
    parameter int MAX_ENTRIES = sfd_pkg::MAX_ENTRIES_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // configuration
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [sfd_pkg::CFG_W-1:0]   cfg_data,
    // input words
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [sfd_pkg::KEY_W-1:0]   s_probe_index,
    input  logic [sfd_pkg::ALLOW_W-1:0] s_mismatch_allowance,
    // result words
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [sfd_pkg::KEY_W-1:0]   m_sorted_index,
    output logic [sfd_pkg::ALLOW_W-1:0] m_sorted_mismatch,
    output logic                        m_has_duplicate,
    output logic [sfd_pkg::POS_W-1:0]   m_duplicate_position,
    output logic                        m_last
);

    localparam int AW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int PW = sfd_pkg::POS_W;

    sfd_pkg::state_t state_reg, state_next;

    logic [sfd_pkg::CFG_W-1:0]  probe_count_reg, probe_count_next;
    logic [CW-1:0]              loaded_reg, loaded_next;
    logic [AW-1:0]              j_reg, j_next;
    logic [AW-1:0]              k_reg, k_next;
    sfd_pkg::entry_t            cur_reg, cur_next;
    logic [sfd_pkg::KEY_W-1:0]  prev_key_reg, prev_key_next;
    logic                       dup_reg, dup_next;
    logic [PW-1:0]              dpos_reg, dpos_next;

    logic                        m_valid_reg, m_valid_next;
    sfd_pkg::entry_t             out_entry_reg, out_entry_next;
    logic                        out_dup_reg, out_dup_next;
    logic [PW-1:0]               out_dpos_reg, out_dpos_next;
    logic                        out_last_reg, out_last_next;

    logic            ram_wr_en, ram_rd_en;
    logic [AW-1:0]   ram_wr_addr, ram_rd_addr;
    sfd_pkg::entry_t ram_wr_data, ram_rd_data;

    logic [7:0]      count_wide;
    logic [CW-1:0]   n_eff;
    logic [AW-1:0]   n_last;
    logic            s_fire, slot_free, ins_done, set_full, shift_up;
    logic [AW-1:0]   load_pos;
    logic [AW-1:0]   k_prev;
    logic [AW+PW-1:0] k_prev_wide;

    // effective count: zero acts as one, large values saturate
    assign count_wide = {4'b0, probe_count_reg};
    always_comb begin
        if (probe_count_reg == '0) begin
            n_eff = CW'(1);
        end else if (count_wide > 8'(MAX_ENTRIES)) begin
            n_eff = CW'(MAX_ENTRIES);
        end else begin
            n_eff = CW'(count_wide);
        end
    end
    assign n_last = AW'(n_eff - CW'(1));

    assign s_ready   = (state_reg == sfd_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;
    assign s_fire    = s_valid && s_ready;
    assign slot_free = !m_valid_reg || m_ready;

    // a set dropped by a lowered count restarts at slot zero
    assign load_pos = (loaded_reg >= n_eff) ? '0 : loaded_reg[AW-1:0];

    // insertion step: stored word moves up while its key is strictly larger
    assign shift_up = ram_rd_data.key > cur_reg.key;
    assign ins_done = ((state_reg == sfd_pkg::ST_INS_READ) && (j_reg == '0)) ||
                      ((state_reg == sfd_pkg::ST_INS_CMP) && !shift_up);
    assign set_full = (loaded_reg == n_eff);

    assign k_prev      = k_reg - AW'(1);
    assign k_prev_wide = {{PW{1'b0}}, k_prev};

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            sfd_pkg::ST_IDLE: begin
                if (s_fire) state_next = sfd_pkg::ST_INS_READ;
            end
            sfd_pkg::ST_INS_READ: begin
                if (j_reg == '0) begin
                    state_next = set_full ? sfd_pkg::ST_SCAN_READ : sfd_pkg::ST_IDLE;
                end else begin
                    state_next = sfd_pkg::ST_INS_CMP;
                end
            end
            sfd_pkg::ST_INS_CMP: begin
                if (shift_up) begin
                    state_next = sfd_pkg::ST_INS_READ;
                end else begin
                    state_next = set_full ? sfd_pkg::ST_SCAN_READ : sfd_pkg::ST_IDLE;
                end
            end
            sfd_pkg::ST_SCAN_READ: begin
                state_next = sfd_pkg::ST_SCAN_CHECK;
            end
            sfd_pkg::ST_SCAN_CHECK: begin
                state_next = (k_reg == n_last) ? sfd_pkg::ST_EMIT_READ
                                               : sfd_pkg::ST_SCAN_READ;
            end
            sfd_pkg::ST_EMIT_READ: begin
                state_next = sfd_pkg::ST_EMIT_LOAD;
            end
            sfd_pkg::ST_EMIT_LOAD: begin
                if (slot_free) begin
                    state_next = (k_reg == n_last) ? sfd_pkg::ST_IDLE
                                                   : sfd_pkg::ST_EMIT_READ;
                end
            end
            default: state_next = sfd_pkg::ST_IDLE;
        endcase
    end

    // datapath and RAM controls
    always_comb begin
        probe_count_next = probe_count_reg;
        loaded_next      = loaded_reg;
        j_next           = j_reg;
        k_next           = k_reg;
        cur_next         = cur_reg;
        prev_key_next    = prev_key_reg;
        dup_next         = dup_reg;
        dpos_next        = dpos_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        out_entry_next   = out_entry_reg;
        out_dup_next     = out_dup_reg;
        out_dpos_next    = out_dpos_reg;
        out_last_next    = out_last_reg;
        ram_wr_en        = 1'b0;
        ram_wr_addr      = j_reg;
        ram_wr_data      = cur_reg;
        ram_rd_en        = 1'b0;
        ram_rd_addr      = k_reg;

        if (cfg_valid) probe_count_next = cfg_data;

        unique case (state_reg)
            sfd_pkg::ST_IDLE: begin
                if (s_fire) begin
                    j_next       = load_pos;
                    cur_next.key = s_probe_index;
                    cur_next.allow = s_mismatch_allowance;
                    loaded_next  = CW'(load_pos) + CW'(1);
                end
            end
            sfd_pkg::ST_INS_READ: begin
                if (j_reg == '0) begin
                    ram_wr_en = 1'b1;
                end else begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = j_reg - AW'(1);
                end
            end
            sfd_pkg::ST_INS_CMP: begin
                ram_wr_en = 1'b1;
                if (shift_up) begin
                    ram_wr_data = ram_rd_data;
                    j_next      = j_reg - AW'(1);
                end
            end
            sfd_pkg::ST_SCAN_READ: begin
                ram_rd_en = 1'b1;
            end
            sfd_pkg::ST_SCAN_CHECK: begin
                // first adjacent pair with equal keys
                if ((k_reg != '0) && !dup_reg && (prev_key_reg == ram_rd_data.key)) begin
                    dup_next  = 1'b1;
                    dpos_next = k_prev_wide[PW-1:0];
                end
                prev_key_next = ram_rd_data.key;
                k_next = (k_reg == n_last) ? '0 : k_reg + AW'(1);
            end
            sfd_pkg::ST_EMIT_READ: begin
                ram_rd_en = 1'b1;
            end
            sfd_pkg::ST_EMIT_LOAD: begin
                if (slot_free) begin
                    m_valid_next   = 1'b1;
                    out_entry_next = ram_rd_data;
                    out_dup_next   = dup_reg;
                    out_dpos_next  = dpos_reg;
                    out_last_next  = (k_reg == n_last);
                    if (k_reg == n_last) begin
                        k_next      = '0;
                        loaded_next = '0;
                    end else begin
                        k_next = k_reg + AW'(1);
                    end
                end
            end
            default: ;
        endcase

        // fresh duplicate search for each completed set
        if (ins_done && set_full) begin
            k_next    = '0;
            dup_next  = 1'b0;
            dpos_next = '0;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= sfd_pkg::ST_IDLE;
            probe_count_reg <= sfd_pkg::PROBE_COUNT_RST;
            loaded_reg      <= '0;
            k_reg           <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            probe_count_reg <= probe_count_next;
            loaded_reg      <= loaded_next;
            k_reg           <= k_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        j_reg         <= j_next;
        cur_reg       <= cur_next;
        prev_key_reg  <= prev_key_next;
        dup_reg       <= dup_next;
        dpos_reg      <= dpos_next;
        out_entry_reg <= out_entry_next;
        out_dup_reg   <= out_dup_next;
        out_dpos_reg  <= out_dpos_next;
        out_last_reg  <= out_last_next;
    end

    sfd_entry_ram #(
        .DEPTH (MAX_ENTRIES),
        .AW    (AW)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign m_valid              = m_valid_reg;
    assign m_sorted_index       = out_entry_reg.key;
    assign m_sorted_mismatch    = out_entry_reg.allow;
    assign m_has_duplicate      = out_dup_reg;
    assign m_duplicate_position = out_dpos_reg;
    assign m_last               = out_last_reg;

endmodule

FILE: src/sfd_checker.sv
// Port-level checks of the sort core, bound to the top level.
`include "sort_and_find_duplicate_core_defines.svh"

module sfd_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_valid,
    input logic                        s_ready,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic [sfd_pkg::KEY_W-1:0]   m_sorted_index,
    input logic [sfd_pkg::ALLOW_W-1:0] m_sorted_mismatch,
    input logic                        m_has_duplicate,
    input logic [sfd_pkg::POS_W-1:0]   m_duplicate_position,
    input logic                        m_last
);

    // a stalled result word holds
    `SFD_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_sorted_index) && $stable(m_sorted_mismatch) && $stable(m_last))

    // an accepted word starts an insertion, so input closes at once
    `SFD_ASSERT_NEXT(a_busy_after_load, aclk, aresetn, s_valid && s_ready, !s_ready)

    // no new input while a sorted run is still being emitted
    `SFD_ASSERT_NOW(a_no_load_mid_run, aclk, aresetn, m_valid && !m_last, !s_ready)

    // position reads zero when no duplicate was found
    `SFD_ASSERT_NOW(a_dpos_zero, aclk, aresetn, m_valid && !m_has_duplicate, m_duplicate_position == '0)

endmodule

bind sort_and_find_duplicate_core sfd_checker u_sfd_checker (.*);
